// File: rtl/bfra_pkg.sv
// Shared types and codes for the best-fit region allocator.
package bfra_pkg;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam int SIZE_W  = 17;
  localparam int ALIGN_W = 4;
  localparam int ADDR_W  = 16;
  localparam int PAD_W   = 15;

  typedef struct packed {
    logic                cmd;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  align_log2;
    logic [ADDR_W-1:0]   release_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] grant_address;
    logic [1:0]        status;
    logic [SIZE_W-1:0] bytes_in_use;
  } out_t;

  typedef struct packed {
    logic pop;
    logic push;
  } q_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_AEDIT,
    S_APUSH,
    S_RSCAN,
    S_RFREE,
    S_DONE
  } state_t;

endpackage

// File: rtl/bfra_cell.sv
// One descriptor cell of the list chain: holds, takes its neighbor, or loads.
module bfra_cell import bfra_pkg::*; #(
  parameter int          W      = 8,
  parameter bit          RST_EN = 1'b0,
  parameter logic [W-1:0] RST_VAL = '0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift_en,
  input  logic [W-1:0] nbr,
  input  logic         load,
  input  logic [W-1:0] load_data,
  output logic [W-1:0] q
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift_en) begin
      data_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n && RST_EN) begin
      data_r <= RST_VAL;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

// File: rtl/bfra_queue.sv
// Ordered list held in a chain of cells: pop at the head, push at the tail.
module bfra_queue import bfra_pkg::*; #(
  parameter int           DEPTH      = 64,
  parameter int           W          = 8,
  parameter int           INIT_COUNT = 0,
  parameter logic [W-1:0] INIT_HEAD  = '0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  q_ctl_t                       ctl,
  input  logic [W-1:0]                 push_data,
  output logic [W-1:0]                 head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int CW = $clog2(DEPTH+1);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] tail;
  logic [W-1:0]  q [DEPTH];

  assign tail    = cnt_r - CW'(ctl.pop);
  assign cnt_nxt = cnt_r - CW'(ctl.pop) + CW'(ctl.push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(INIT_COUNT);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [W-1:0] nbr;
    if (k == DEPTH - 1) begin : g_last
      assign nbr = q[k];
    end else begin : g_mid
      assign nbr = q[k+1];
    end
    bfra_cell #(
      .W      (W),
      .RST_EN (k == 0 && INIT_COUNT > 0),
      .RST_VAL(INIT_HEAD)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.pop),
      .nbr      (nbr),
      .load     (ctl.push && (tail == CW'(k))),
      .load_data(push_data),
      .q        (q[k])
    );
  end

  assign head  = q[0];
  assign count = cnt_r;

endmodule

// File: rtl/best_fit_region_allocator.sv
// Best-fit region allocator: free and used chunk lists in cell chains, one sequencer.
// Allocate: one pass over the free list to pick, one to unlink and split, one over
//   the used list to push.
// Release: one pass over the used list, one over the free list to merge.
// One request at a time; the result sits in an output register while the next is taken.
// Synchronous reset: one free chunk covers the whole region, threshold 16.
module best_fit_region_allocator import bfra_pkg::*; #(
  parameter int REGION_BYTES = 65536,
  parameter int CHUNK_SLOTS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int LW = $clog2(REGION_BYTES + 1);
  localparam int CW = $clog2(CHUNK_SLOTS + 1);
  localparam int XW = LW + 18;
  localparam int FW = 2 * LW;
  localparam int UW = 2 * LW + PAD_W;
  localparam logic [FW-1:0] FREE_INIT = {LW'(0), LW'(REGION_BYTES)};

  state_t state_r, state_nxt;
  logic [CW-1:0]     rem_r, rem_nxt, pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [LW-1:0]     hold_start_r, hold_start_nxt, hold_len_r, hold_len_nxt;
  logic              ins_done_r, ins_done_nxt, ins_en_r, ins_en_nxt;
  logic [LW-1:0]     ins_start_r, ins_start_nxt, ins_len_r, ins_len_nxt;
  logic              drop_en_r, drop_en_nxt;
  logic [CW-1:0]     best_pos_r, best_pos_nxt;
  logic [LW-1:0]     best_start_r, best_start_nxt, best_len_r, best_len_nxt;
  logic [LW-1:0]     best_left_r, best_left_nxt;
  logic [PAD_W-1:0]  best_pad_r, best_pad_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ALIGN_W-1:0] align_r, align_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SIZE_W-1:0] thr_r;
  logic [LW-1:0]     used_r, used_nxt;
  logic [ADDR_W-1:0] grant_r, grant_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  q_ctl_t        f_ctl, u_ctl;
  logic [FW-1:0] f_wdata, f_head;
  logic [UW-1:0] u_wdata, u_head;
  logic [CW-1:0] f_cnt, u_cnt;

  logic [LW-1:0]    fh_start, fh_len, uh_start, uh_len;
  logic [PAD_W-1:0] uh_pad, mask, pad;
  logic [PAD_W:0]   mask_w;
  logic [XW-1:0]    neg, req, left_x, grant_x;
  logic             fit, is_drop, split;
  logic [31:0]      used32;

  assign {fh_start, fh_len}         = f_head;
  assign {uh_start, uh_len, uh_pad} = u_head;

  assign mask_w  = ((PAD_W+1)'(1) << align_r) - (PAD_W+1)'(1);
  assign mask    = mask_w[PAD_W-1:0];
  assign neg     = XW'(0) - XW'(fh_start);
  assign pad     = neg[PAD_W-1:0] & mask;
  assign req     = XW'(size_r) + XW'(pad);
  assign fit     = req <= XW'(fh_len);
  assign left_x  = XW'(fh_len) - req;
  assign is_drop = drop_en_r && (rem_r != '0) && (pos_r == best_pos_r);
  assign split   = ((XW'(f_cnt) + XW'(u_cnt)) < XW'(CHUNK_SLOTS)) &&
                   (XW'(best_left_r) >= XW'(thr_r)) && (best_left_r != '0);
  assign grant_x = XW'(best_start_r) + XW'(best_pad_r);
  assign used32  = 32'(used_r);

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    hold_v_nxt     = hold_v_r;
    hold_start_nxt = hold_start_r;
    hold_len_nxt   = hold_len_r;
    ins_done_nxt   = ins_done_r;
    ins_en_nxt     = ins_en_r;
    ins_start_nxt  = ins_start_r;
    ins_len_nxt    = ins_len_r;
    drop_en_nxt    = drop_en_r;
    best_pos_nxt   = best_pos_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    best_left_nxt  = best_left_r;
    best_pad_nxt   = best_pad_r;
    size_nxt       = size_r;
    align_nxt      = align_r;
    addr_nxt       = addr_r;
    used_nxt       = used_r;
    grant_nxt      = grant_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    f_ctl          = '0;
    u_ctl          = '0;
    f_wdata        = f_head;
    u_wdata        = u_head;
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          size_nxt   = in_data.request_size;
          align_nxt  = in_data.align_log2;
          addr_nxt   = in_data.release_address;
          grant_nxt  = '0;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          if (in_data.cmd == CMD_ALLOC) begin
            rem_nxt = f_cnt;
            if (XW'(used_r) + XW'(in_data.request_size) > XW'(REGION_BYTES)) begin
              status_nxt = ST_NO_SPACE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_ASCAN;
            end
          end else begin
            rem_nxt = u_cnt;
            if (XW'(in_data.release_address) >= XW'(REGION_BYTES)) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_RSCAN;
            end
          end
        end
      end

      S_ASCAN: begin
        if (rem_r == '0) begin
          if (!found_r) begin
            status_nxt = ST_NO_SPACE;
            state_nxt  = S_DONE;
          end else begin
            ins_en_nxt    = split;
            ins_start_nxt = best_start_r + best_len_r - best_left_r;
            ins_len_nxt   = best_left_r;
            best_len_nxt  = split ? (best_len_r - best_left_r) : best_len_r;
            used_nxt      = used_r + (split ? (best_len_r - best_left_r) : best_len_r);
            grant_nxt     = grant_x[ADDR_W-1:0];
            drop_en_nxt   = 1'b1;
            hold_v_nxt    = 1'b0;
            ins_done_nxt  = 1'b0;
            rem_nxt       = f_cnt;
            pos_nxt       = '0;
            state_nxt     = S_AEDIT;
          end
        end else begin
          f_ctl.pop  = 1'b1;
          f_ctl.push = 1'b1;
          if (fit && (!found_r || (left_x < XW'(best_left_r)))) begin
            found_nxt      = 1'b1;
            best_pos_nxt   = pos_r;
            best_start_nxt = fh_start;
            best_len_nxt   = fh_len;
            best_pad_nxt   = pad;
            best_left_nxt  = left_x[LW-1:0];
          end
          rem_nxt = rem_r - CW'(1);
          pos_nxt = pos_r + CW'(1);
        end
      end

      S_AEDIT, S_RFREE: begin
        if (hold_v_r) begin
          if (is_drop) begin
            f_ctl.pop = 1'b1;
            rem_nxt   = rem_r - CW'(1);
            pos_nxt   = pos_r + CW'(1);
          end else if (rem_r != '0 &&
                       XW'(hold_start_r) + XW'(hold_len_r) == XW'(fh_start)) begin
            f_ctl.pop  = 1'b1;
            f_ctl.push = 1'b1;
            f_wdata    = {hold_start_r, hold_len_r + fh_len};
            hold_v_nxt = 1'b0;
            rem_nxt    = rem_r - CW'(1);
            pos_nxt    = pos_r + CW'(1);
          end else begin
            f_ctl.push = 1'b1;
            f_wdata    = {hold_start_r, hold_len_r};
            hold_v_nxt = 1'b0;
          end
        end else if (rem_r == '0) begin
          if (ins_en_r && !ins_done_r) begin
            f_ctl.push   = 1'b1;
            f_wdata      = {ins_start_r, ins_len_r};
            ins_done_nxt = 1'b1;
          end else if (state_r == S_AEDIT) begin
            drop_en_nxt  = 1'b0;
            ins_done_nxt = 1'b0;
            rem_nxt      = u_cnt;
            state_nxt    = S_APUSH;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (is_drop) begin
          f_ctl.pop = 1'b1;
          rem_nxt   = rem_r - CW'(1);
          pos_nxt   = pos_r + CW'(1);
        end else if (ins_en_r && !ins_done_r) begin
          if (XW'(ins_start_r) + XW'(ins_len_r) == XW'(fh_start)) begin
            f_ctl.pop    = 1'b1;
            f_ctl.push   = 1'b1;
            f_wdata      = {ins_start_r, fh_len + ins_len_r};
            ins_done_nxt = 1'b1;
            rem_nxt      = rem_r - CW'(1);
            pos_nxt      = pos_r + CW'(1);
          end else if (XW'(fh_start) + XW'(fh_len) == XW'(ins_start_r)) begin
            f_ctl.pop      = 1'b1;
            hold_v_nxt     = 1'b1;
            hold_start_nxt = fh_start;
            hold_len_nxt   = fh_len + ins_len_r;
            ins_done_nxt   = 1'b1;
            rem_nxt        = rem_r - CW'(1);
            pos_nxt        = pos_r + CW'(1);
          end else if (fh_start > ins_start_r) begin
            f_ctl.push   = 1'b1;
            f_wdata      = {ins_start_r, ins_len_r};
            ins_done_nxt = 1'b1;
          end else begin
            f_ctl.pop  = 1'b1;
            f_ctl.push = 1'b1;
            rem_nxt    = rem_r - CW'(1);
            pos_nxt    = pos_r + CW'(1);
          end
        end else begin
          f_ctl.pop  = 1'b1;
          f_ctl.push = 1'b1;
          rem_nxt    = rem_r - CW'(1);
          pos_nxt    = pos_r + CW'(1);
        end
      end

      S_APUSH: begin
        if (!ins_done_r) begin
          u_ctl.push   = 1'b1;
          u_wdata      = {best_start_r, best_len_r, best_pad_r};
          ins_done_nxt = 1'b1;
        end else if (rem_r != '0) begin
          u_ctl.pop  = 1'b1;
          u_ctl.push = 1'b1;
          rem_nxt    = rem_r - CW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RSCAN: begin
        if (rem_r == '0) begin
          if (found_r) begin
            used_nxt      = used_r - best_len_r;
            ins_en_nxt    = 1'b1;
            ins_start_nxt = best_start_r;
            ins_len_nxt   = best_len_r;
            drop_en_nxt   = 1'b0;
            hold_v_nxt    = 1'b0;
            ins_done_nxt  = 1'b0;
            rem_nxt       = f_cnt;
            pos_nxt       = '0;
            state_nxt     = S_RFREE;
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end else begin
          u_ctl.pop = 1'b1;
          if (!found_r && (XW'(uh_start) + XW'(uh_pad) == XW'(addr_r))) begin
            found_nxt      = 1'b1;
            best_start_nxt = uh_start;
            best_len_nxt   = uh_len;
          end else begin
            u_ctl.push = 1'b1;
          end
          rem_nxt = rem_r - CW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.grant_address = (status_r == ST_OK) ? grant_r : '0;
          out_data_nxt.status        = status_r;
          out_data_nxt.bytes_in_use  = used32[SIZE_W-1:0];
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      thr_r       <= SIZE_W'(16);
      found_r     <= 1'b0;
      hold_v_r    <= 1'b0;
      ins_done_r  <= 1'b0;
      ins_en_r    <= 1'b0;
      drop_en_r   <= 1'b0;
      rem_r       <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      thr_r       <= cfg_we ? cfg_wdata : thr_r;
      found_r     <= found_nxt;
      hold_v_r    <= hold_v_nxt;
      ins_done_r  <= ins_done_nxt;
      ins_en_r    <= ins_en_nxt;
      drop_en_r   <= drop_en_nxt;
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_start_r <= hold_start_nxt;
    hold_len_r   <= hold_len_nxt;
    ins_start_r  <= ins_start_nxt;
    ins_len_r    <= ins_len_nxt;
    best_pos_r   <= best_pos_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
    best_left_r  <= best_left_nxt;
    best_pad_r   <= best_pad_nxt;
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    addr_r       <= addr_nxt;
    grant_r      <= grant_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
  end

  bfra_queue #(
    .DEPTH     (CHUNK_SLOTS),
    .W         (FW),
    .INIT_COUNT(1),
    .INIT_HEAD (FREE_INIT)
  ) u_free (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (f_ctl),
    .push_data(f_wdata),
    .head     (f_head),
    .count    (f_cnt)
  );

  bfra_queue #(
    .DEPTH     (CHUNK_SLOTS),
    .W         (UW),
    .INIT_COUNT(0),
    .INIT_HEAD ('0)
  ) u_used (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (u_ctl),
    .push_data(u_wdata),
    .head     (u_head),
    .count    (u_cnt)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sim/best_fit_region_allocator_checker.sv
// Checker for the best-fit region allocator: predicts each result and compares transfers.
`timescale 1ns / 100ps
module best_fit_region_allocator_checker import bfra_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                mismatches,
  output int                pending
);

  localparam int REGION = 65536;
  localparam int SLOTS  = 64;
  localparam int NIL    = SLOTS;

  typedef enum logic [1:0] {K_IDLE, K_FREE, K_USED} kind_t;

  kind_t       kind [SLOTS];
  int unsigned base [SLOTS];
  int unsigned span [SLOTS];
  int unsigned pad  [SLOTS];
  int unsigned nxt  [SLOTS];
  int unsigned free_first, spare_first, busy_first, held_bytes, split_min;
  out_t        results_due[$];

  function automatic void clear_region();
    for (int i = 0; i < SLOTS; i++) begin
      kind[i] = K_IDLE;
      base[i] = 0;
      span[i] = 0;
      pad[i]  = 0;
      nxt[i]  = (i >= 1 && i + 1 < SLOTS) ? i + 1 : NIL;
    end
    kind[0] = K_FREE;
    span[0] = REGION;
    free_first  = 0;
    spare_first = 1;
    busy_first  = NIL;
    held_bytes  = 0;
    split_min   = 16;
  endfunction

  function automatic void retire_slot(int unsigned s);
    int unsigned cur, prv, n;
    cur = spare_first;
    prv = NIL;
    n = 0;
    kind[s] = K_IDLE;
    base[s] = 0;
    span[s] = 0;
    pad[s]  = 0;
    while (cur < NIL && s > cur && n < SLOTS) begin
      prv = cur;
      cur = nxt[cur];
      n++;
    end
    if (prv < NIL) begin
      nxt[prv] = s;
      nxt[s] = cur;
    end else begin
      nxt[s] = spare_first;
      spare_first = s;
    end
  endfunction

  function automatic void return_slot(int unsigned s);
    int unsigned cur, prv, n, nx;
    cur = free_first;
    prv = NIL;
    n = 0;
    kind[s] = K_FREE;
    pad[s] = 0;
    while (cur < NIL && n < SLOTS) begin
      if (base[s] + span[s] == base[cur]) begin
        base[cur] = base[s];
        span[cur] += span[s];
        retire_slot(s);
        return;
      end
      if (base[cur] + span[cur] == base[s]) begin
        span[cur] += span[s];
        retire_slot(s);
        nx = nxt[cur];
        if (nx < NIL && base[cur] + span[cur] == base[nx]) begin
          span[cur] += span[nx];
          nxt[cur] = nxt[nx];
          retire_slot(nx);
        end
        return;
      end
      if (base[cur] > base[s]) break;
      prv = cur;
      cur = nxt[cur];
      n++;
    end
    if (prv < NIL) begin
      nxt[prv] = s;
      nxt[s] = cur;
    end else begin
      nxt[s] = free_first;
      free_first = s;
    end
  endfunction

  function automatic logic [1:0] carve(int unsigned size, int unsigned al,
                                       output int unsigned grant);
    int unsigned mask, cur, prv, n, best, best_prv, best_left, best_pad;
    int unsigned p, req, st, len, need, left, sp;
    mask = (32'd1 << al) - 1;
    cur = free_first;
    prv = NIL;
    n = 0;
    best = NIL;
    best_prv = NIL;
    best_left = 0;
    best_pad = 0;
    grant = 0;
    if (held_bytes + size > REGION) return ST_NO_SPACE;
    while (cur < NIL && n < SLOTS) begin
      p = (0 - base[cur]) & mask;
      req = size + p;
      if (req <= span[cur] && (best == NIL || span[cur] - req < best_left)) begin
        best = cur;
        best_prv = prv;
        best_left = span[cur] - req;
        best_pad = p;
      end
      prv = cur;
      cur = nxt[cur];
      n++;
    end
    if (best == NIL) return ST_NO_SPACE;
    if (best_prv < NIL) nxt[best_prv] = nxt[best];
    else free_first = nxt[best];
    st = base[best];
    len = span[best];
    need = best_pad + size;
    left = len - need;
    if (spare_first < NIL && left >= split_min && left != 0) begin
      sp = spare_first;
      spare_first = nxt[sp];
      base[sp] = st + need;
      span[sp] = left;
      pad[sp] = 0;
      return_slot(sp);
      len -= left;
    end
    held_bytes += len;
    kind[best] = K_USED;
    base[best] = st;
    span[best] = len;
    pad[best] = best_pad;
    nxt[best] = busy_first;
    busy_first = best;
    grant = st + best_pad;
    return ST_OK;
  endfunction

  function automatic logic [1:0] give_back(int unsigned addr);
    int unsigned cur, prv, n;
    cur = busy_first;
    prv = NIL;
    n = 0;
    if (addr >= REGION) return ST_NOT_FOUND;
    while (cur < NIL && n < SLOTS) begin
      if (base[cur] + pad[cur] == addr) begin
        if (prv < NIL) nxt[prv] = nxt[cur];
        else busy_first = nxt[cur];
        held_bytes -= span[cur];
        return_slot(cur);
        return ST_OK;
      end
      prv = cur;
      cur = nxt[cur];
      n++;
    end
    return ST_NOT_FOUND;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    clear_region();
  end

  always @(posedge clk) begin
    int unsigned grant;
    out_t due, got;
    if (!rst_n) begin
      clear_region();
      results_due.delete();
    end else begin
      if (cfg_we) split_min = 32'(cfg_wdata);
      if (out_valid && !out_stall) begin
        got = out_data;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %p", got);
        end else begin
          due = results_due.pop_front();
          if (got.grant_address !== due.grant_address || got.status !== due.status ||
              got.bytes_in_use !== due.bytes_in_use) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected addr %0d st %0d used %0d, got %0d %0d %0d",
                       due.grant_address, due.status, due.bytes_in_use,
                       got.grant_address, got.status, got.bytes_in_use);
          end
        end
      end
      if (in_valid && !in_stall) begin
        grant = 0;
        if (in_data.cmd == CMD_ALLOC)
          due.status = carve(32'(in_data.request_size), 32'(in_data.align_log2), grant);
        else
          due.status = give_back(32'(in_data.release_address));
        due.grant_address = grant[ADDR_W-1:0];
        due.bytes_in_use = held_bytes[SIZE_W-1:0];
        results_due.push_back(due);
      end
    end
    pending = results_due.size();
  end

endmodule

// File: sim/best_fit_region_allocator_tb.sv
// Testbench top for the best-fit region allocator: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module best_fit_region_allocator_tb import bfra_pkg::*;;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  int                mismatches, pending;
  logic              steady = 1'b0;
  logic              cmds_sent[$];
  logic [ADDR_W-1:0] live[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  best_fit_region_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  best_fit_region_allocator_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  always @(negedge clk) out_stall <= !steady && $urandom_range(0, 99) < 9;

  // record granted addresses for later release
  always @(posedge clk) begin
    logic c;
    if (rst_n && out_valid && !out_stall && cmds_sent.size() > 0) begin
      c = cmds_sent.pop_front();
      if (c == CMD_ALLOC && out_data.status == ST_OK) live.push_back(out_data.grant_address);
    end
  end

  task automatic send(input in_t it);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmds_sent.push_back(it.cmd);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [SIZE_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_t alloc_req(input int unsigned size, input int unsigned al);
    in_t it;
    it.cmd = CMD_ALLOC;
    it.request_size = SIZE_W'(size);
    it.align_log2 = ALIGN_W'(al);
    it.release_address = ADDR_W'($urandom);
    return it;
  endfunction

  function automatic in_t release_req(input int unsigned addr);
    in_t it;
    it.cmd = CMD_RELEASE;
    it.request_size = SIZE_W'($urandom_range(1, 65536));
    it.align_log2 = ALIGN_W'($urandom);
    it.release_address = ADDR_W'(addr);
    return it;
  endfunction

  function automatic in_t random_req();
    int unsigned r, k;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      if ($urandom_range(0, 1)) return release_req($urandom_range(0, 65535));
      return alloc_req($urandom_range(1, 65536), $urandom_range(0, 15));
    end
    if (live.size() > 0 && (r < 45 || live.size() > 48)) begin
      k = $urandom_range(0, live.size() - 1);
      r = 32'(live[k]);
      live.delete(k);
      return release_req(r);
    end
    k = $urandom_range(0, 99);
    return alloc_req(k < 85 ? $urandom_range(1, 512) :
                     k < 97 ? $urandom_range(1, 8192) : $urandom_range(1, 65536),
                     $urandom_range(0, 9) < 8 ? $urandom_range(0, 6) : $urandom_range(0, 15));
  endfunction

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [SIZE_W-1:0] thresholds[4];
    int unsigned sent;
    thresholds = '{17'd0, 17'd65536, 17'd1, 17'd0};
    thresholds[2] = SIZE_W'($urandom_range(1, 64));
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full region, zero size, alignment extremes, unknown addresses
    send(alloc_req(65536, 0));
    send(alloc_req(65536, 15));
    send(alloc_req(1, 0));
    send(alloc_req(0, 15));
    send(alloc_req(100, 15));
    send(alloc_req(65535, 0));
    send(alloc_req(3, 4));
    send(alloc_req(20, 3));
    send(release_req(65535));
    send(release_req(12345));
    send(release_req(16'h8000));
    settle();
    while (live.size() > 0) send(release_req(32'(live.pop_front())));
    send(release_req(0));
    for (int i = 0; i < 70; i += 10) send(alloc_req(i + 1, 0));

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      set_threshold(thresholds[ph]);
      for (int i = 0; i < 450; i++) begin
        steady <= (sent >= 700 && sent < 1000);
        send(random_req());
        sent++;
      end
    end

    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
